FILE: rtl/pfts_pkg.sv
// shared types, widths and codes of the per-flow token bucket shaper
package pfts_pkg;

   localparam int FLOWS_DEF       = 4;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int FLOW_ID_W  = 2;
   localparam int FLOW_EXT_W = 5;
   localparam int SIZE_W     = 11;
   localparam int TOKEN_W    = 17;
   localparam int BAL_W      = TOKEN_W + 1;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int RATE_REGS  = 4;
   localparam int RATE_IDX_W = 2;

   localparam logic [TOKEN_W-1:0] TOKEN_CAP_RESET = 17'd100000;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE_FLOW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOKEN_CAP  = 3'd4;

   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPT  = 2'd0,
      KIND_DROP    = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

   typedef struct packed {
      logic capture;
      logic arrive;
      logic tick_add;
      logic release_pkt;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic req_tick;
      logic req_in_range;
      logic can_release;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/pfts_ctrl.sv
// controller state machine of the shaper
module pfts_ctrl
   import pfts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ARRIVE = 5'b00010,
      ST_ADD    = 5'b00100,
      ST_CHK    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!status.req_tick) begin
                  state_in = ST_ARRIVE;
               end else if (status.req_in_range) begin
                  state_in = ST_ADD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ARRIVE: begin
            if (status.out_free) begin
               cmd.arrive = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_ADD: begin
            cmd.tick_add = 1'b1;
            state_in     = ST_CHK;
         end
         ST_CHK: begin
            if (!status.can_release) begin
               state_in = ST_DONE;
            end else if (status.out_free) begin
               cmd.release_pkt = 1'b1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_cmd_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("transaction accepted but controller stayed idle");

   a_release_only_in_chk: assert property (@(posedge clock) disable iff (reset)
      cmd.release_pkt |-> (state_ff == ST_CHK && status.can_release))
      else $error("release issued outside the release loop");
`endif

endmodule

FILE: rtl/pfts_datapath.sv
// datapath of the shaper: queues, token balances, config and result register
module pfts_datapath
   import pfts_pkg::*;
#(
   parameter int FLOWS       = FLOWS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_type,
   input  logic [FLOW_ID_W-1:0] req_flow_id,
   input  logic [SIZE_W-1:0]    req_pkt_size,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [FLOW_ID_W-1:0] rsp_out_flow,
   output logic [SIZE_W-1:0]    rsp_out_size,
   output logic [TOKEN_W-1:0]   rsp_token_balance,
   output logic                 rsp_last,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TOKEN_W-1:0]   csr_wdata,
   input  cmd_type              cmd,
   output status_type           status
);

   localparam int FW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(FLOWS * QUEUE_DEPTH);
   localparam int MEM_DEPTH = FLOWS * QUEUE_DEPTH;

   // configuration
   logic [TOKEN_W-1:0] rate_ff [RATE_REGS];
   logic [TOKEN_W-1:0] cap_ff;

   // captured transaction
   logic                 type_ff;
   logic [FLOW_ID_W-1:0] flow_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic                 in_range_ff;

   // per-flow state
   logic [TOKEN_W-1:0] tokens_ff [FLOWS];
   logic [TOKEN_W-1:0] tokens_in [FLOWS];
   logic [PW-1:0]      head_ff   [FLOWS];
   logic [PW-1:0]      head_in   [FLOWS];
   logic [PW-1:0]      tail_ff   [FLOWS];
   logic [PW-1:0]      tail_in   [FLOWS];
   logic [CW-1:0]      count_ff  [FLOWS];
   logic [CW-1:0]      count_in  [FLOWS];

   logic [BAL_W-1:0] bal_ff, bal_in;

   logic [SIZE_W-1:0] qmem [MEM_DEPTH];
   logic [SIZE_W-1:0] rd_data_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [FLOW_ID_W-1:0] rsp_flow_ff;
   logic [SIZE_W-1:0]    rsp_size_ff, rsp_size_in;
   logic [TOKEN_W-1:0]   rsp_bal_ff, rsp_bal_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [FLOW_EXT_W-1:0] req_flow_ext, flow_ext;
   logic [FW-1:0]         flow_sel;
   logic                  full, out_free, load;
   logic [PW-1:0]         head_nx, tail_nx, rd_ptr;
   logic [AW-1:0]         rd_addr, wr_addr, base_addr;
   logic                  wr_en;
   logic [BAL_W-1:0]      bal_sum, bal_rel, len_ext;
   logic [TOKEN_W-1:0]    bal_rel_sat, bal_capped;
   logic [TOKEN_W-1:0]    rate_sel;

   assign req_flow_ext = {{(FLOW_EXT_W-FLOW_ID_W){1'b0}}, req_flow_id};
   assign flow_ext     = {{(FLOW_EXT_W-FLOW_ID_W){1'b0}}, flow_ff};
   assign flow_sel     = in_range_ff ? flow_ext[FW-1:0] : '0;

   assign full    = (count_ff[flow_sel] == CW'(QUEUE_DEPTH));
   assign head_nx = (head_ff[flow_sel] == PW'(QUEUE_DEPTH - 1)) ? '0
                    : head_ff[flow_sel] + 1'b1;
   assign tail_nx = (tail_ff[flow_sel] == PW'(QUEUE_DEPTH - 1)) ? '0
                    : tail_ff[flow_sel] + 1'b1;
   assign rd_ptr  = cmd.release_pkt ? head_nx : head_ff[flow_sel];

   assign base_addr = AW'(flow_sel) * AW'(QUEUE_DEPTH);
   assign rd_addr   = base_addr + AW'(rd_ptr);
   assign wr_addr   = base_addr + AW'(tail_ff[flow_sel]);
   assign wr_en     = cmd.arrive && in_range_ff && !full;

   assign rate_sel = rate_ff[flow_ff[RATE_IDX_W-1:0]];
   assign bal_sum  = {1'b0, tokens_ff[flow_sel]} + {1'b0, rate_sel};
   assign len_ext  = {{(BAL_W-SIZE_W){1'b0}}, rd_data_ff};
   assign bal_rel  = bal_ff - len_ext;
   assign bal_rel_sat = bal_rel[BAL_W-1] ? '1 : bal_rel[TOKEN_W-1:0];
   assign bal_capped  = (bal_ff > {1'b0, cap_ff}) ? cap_ff : bal_ff[TOKEN_W-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = cmd.arrive || cmd.release_pkt || cmd.done;

   assign status.req_tick     = (req_type == REQ_TICK);
   assign status.req_in_range = (req_flow_ext < FLOW_EXT_W'(FLOWS));
   assign status.can_release  = (count_ff[flow_sel] != '0) && (len_ext <= bal_ff);
   assign status.out_free     = out_free;

   // queue pointers, counts and balances
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      tokens_in = tokens_ff;
      bal_in    = bal_ff;
      if (wr_en) begin
         tail_in[flow_sel]  = tail_nx;
         count_in[flow_sel] = count_ff[flow_sel] + 1'b1;
      end
      if (cmd.tick_add) begin
         bal_in = bal_sum;
      end
      if (cmd.release_pkt) begin
         head_in[flow_sel]  = head_nx;
         count_in[flow_sel] = count_ff[flow_sel] - 1'b1;
         bal_in             = bal_rel;
      end
      if (cmd.done && in_range_ff) begin
         tokens_in[flow_sel] = bal_capped;
      end
   end

   // result selection
   always_comb begin
      rsp_kind_in = rsp_kind_ff;
      rsp_size_in = rsp_size_ff;
      rsp_bal_in  = rsp_bal_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.arrive) begin
         rsp_kind_in = (in_range_ff && !full) ? KIND_ACCEPT : KIND_DROP;
         rsp_size_in = size_ff;
         rsp_bal_in  = in_range_ff ? tokens_ff[flow_sel] : '0;
         rsp_last_in = 1'b1;
      end else if (cmd.release_pkt) begin
         rsp_kind_in = KIND_RELEASE;
         rsp_size_in = rd_data_ff;
         rsp_bal_in  = bal_rel_sat;
         rsp_last_in = 1'b0;
      end else if (cmd.done) begin
         rsp_kind_in = KIND_DONE;
         rsp_size_in = '0;
         rsp_bal_in  = in_range_ff ? bal_capped : '0;
         rsp_last_in = 1'b1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RATE_REGS; i++) begin
            rate_ff[i] <= '0;
         end
         cap_ff       <= TOKEN_CAP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int f = 0; f < FLOWS; f++) begin
            tokens_ff[f] <= '0;
            head_ff[f]   <= '0;
            tail_ff[f]   <= '0;
            count_ff[f]  <= '0;
         end
      end else begin
         if (csr_write_en) begin
            if (csr_index < CSR_TOKEN_CAP) begin
               rate_ff[csr_index[RATE_IDX_W-1:0]] <= csr_wdata;
            end else if (csr_index == CSR_TOKEN_CAP) begin
               cap_ff <= csr_wdata;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
         tokens_ff    <= tokens_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff     <= req_type;
         flow_ff     <= req_flow_id;
         size_ff     <= req_pkt_size;
         in_range_ff <= status.req_in_range;
      end
      bal_ff <= bal_in;
      if (load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_flow_ff <= flow_ff;
         rsp_size_ff <= rsp_size_in;
         rsp_bal_ff  <= rsp_bal_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // packet length store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         qmem[wr_addr] <= size_ff;
      end
      rd_data_ff <= qmem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_flow      = rsp_flow_ff;
   assign rsp_out_size      = rsp_size_ff;
   assign rsp_token_balance = rsp_bal_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result register overwritten while occupied");

   a_release_shrinks_balance: assert property (@(posedge clock) disable iff (reset)
      cmd.release_pkt |=> (bal_ff <= $past(bal_ff)))
      else $error("release did not lower the running balance");

   a_done_respects_cap: assert property (@(posedge clock) disable iff (reset)
      (cmd.done && in_range_ff) |=> (tokens_ff[$past(flow_sel)] <= $past(cap_ff)))
      else $error("stored balance above token cap after tick");

   a_arrival_type: assert property (@(posedge clock) disable iff (reset)
      (cmd.arrive || cmd.tick_add) |-> (type_ff == (cmd.tick_add ? REQ_TICK : REQ_ARRIVAL)))
      else $error("datapath command does not match captured transaction type");
`endif

endmodule

FILE: rtl/per_flow_token_bucket_shaper.sv
// top level of the per-flow token bucket shaper
//
// request channel (req_*): one transaction per arrival (req_type 0) or per
// tick (req_type 1) for flow req_flow_id. accepted when req_valid is high
// and req_stall is low; req_stall is high while a transaction is in work.
// result channel (rsp_*): kinds accept, drop, release and done; rsp_last
// marks the final result of a request. a result register parts the two
// sides, so a new request is taken while a result waits on rsp_stall.
// arrival: the arrive state loads the result once the result register is
// free, then returns to idle; no new request is taken before that.
// tick on an in-range flow: the add state adds the rate; the check state
// gives one release per cycle while the head length fits the balance and
// the result register is free (the length store read is registered and
// chained off the next head pointer); the done state caps and emits done.
// a stalled receiver holds the result register and the sequencer waits.
// csr_* writes rate_flow0..3 (index 0..3) and token_cap (index 4); write
// only while idle. reset clears balances, queue pointers and counts, rates
// to 0 and token_cap to 100000; the length store needs no clearing pass.
module per_flow_token_bucket_shaper
   import pfts_pkg::*;
#(
   parameter int FLOWS       = FLOWS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [FLOW_ID_W-1:0] req_flow_id,
   input  logic [SIZE_W-1:0]    req_pkt_size,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [FLOW_ID_W-1:0] rsp_out_flow,
   output logic [SIZE_W-1:0]    rsp_out_size,
   output logic [TOKEN_W-1:0]   rsp_token_balance,
   output logic                 rsp_last,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TOKEN_W-1:0]   csr_wdata
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   pfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfts_datapath #(
      .FLOWS       (FLOWS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_flow_id       (req_flow_id),
      .req_pkt_size      (req_pkt_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_flow      (rsp_out_flow),
      .rsp_out_size      (rsp_out_size),
      .rsp_token_balance (rsp_token_balance),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status)
   );

`ifndef SYNTHESIS
   a_no_result_without_request: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && !$past(req_stall)) |-> 1'b0)
      else $error("result appeared with no transaction in work");

   a_stall_while_busy_result: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && rsp_last) |-> $past(req_stall))
      else $error("final result loaded while sequencer was idle");

   a_last_ends_work: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && !rsp_last) |-> req_stall)
      else $error("non-final release without a tick still in work");
`endif

endmodule
